// ===== rtl/core/random_letter_line_generator_assert.svh =====
// assertion macros for the random letter line generator rtl
`ifndef RANDOM_LETTER_LINE_GENERATOR_ASSERT_SVH
`define RANDOM_LETTER_LINE_GENERATOR_ASSERT_SVH

// same-cycle implication, clocked on clk, off during reset
`define RLG_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("rlg assertion failed");

// next-cycle implication, clocked on clk, off during reset
`define RLG_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("rlg assertion failed");

`endif

// ===== rtl/core/rlg_pkg.sv =====
// shared types, constants and letter mapping for the random letter line generator
package rlg_pkg;

	typedef logic [63:0] word_t;

	// commands and status codes
	localparam logic       CMD_START      = 1'b0;
	localparam logic       CMD_NEXT       = 1'b1;
	localparam logic [1:0] STATUS_OK      = 2'd0;
	localparam logic [1:0] STATUS_INVALID = 2'd1;
	localparam logic [1:0] STATUS_NO_JOB  = 2'd2;

	// generator selects
	localparam logic [2:0] GEN_XORSHIFT_STAR = 3'd0;
	localparam logic [2:0] GEN_WYRAND        = 3'd1;
	localparam logic [2:0] GEN_PCG           = 3'd2;
	localparam logic [2:0] GEN_XORSHIFT      = 3'd3;
	localparam logic [2:0] GEN_WEYL          = 3'd4;
	localparam logic [2:0] GEN_WEYL_XOR      = 3'd5;

	// letter map selects
	localparam logic MAP_SCALED = 1'b0;
	localparam logic MAP_MASK   = 1'b1;

	// configuration register indexes
	localparam logic [2:0] REG_GENERATOR_SELECT      = 3'd0;
	localparam logic [2:0] REG_LETTER_MAP_SELECT     = 3'd1;
	localparam logic [2:0] REG_LINE_LENGTH           = 3'd2;
	localparam logic [2:0] REG_LINE_COUNT            = 3'd3;
	localparam logic [2:0] REG_ZERO_SEED_SUBSTITUTE  = 3'd4;

	// line control
	localparam logic [12:0] MAX_LINE_LENGTH  = 13'd4096;
	localparam logic [12:0] LENGTH_RESEED    = 13'd20;
	localparam logic [12:0] RESET_LINE_LEN   = 13'd20;
	localparam logic [31:0] RESET_LINE_COUNT = 32'd1;
	localparam word_t       RESET_SUBSTITUTE = 64'd1;
	localparam logic [7:0]  NEWLINE          = 8'd10;
	localparam logic [2:0]  BYTES_AFTER_DRAW = 3'd7;

	// generator constants
	localparam word_t K_STAR     = 64'h2545f4914f6cdd1d;
	localparam word_t K_WY_ADD   = 64'ha0761d6478bd642f;
	localparam word_t K_WY_MUL1  = 64'he7037ed1a0b428db;
	localparam word_t K_WY_MUL2  = 64'h8ebc6af09c88c6e3;
	localparam word_t K_PCG_MUL  = 64'd6364136223846793005;
	localparam word_t K_PCG_ADD  = 64'd1442695040888963407;
	localparam word_t K_PCG_OUT  = 64'd12605985483714917081;
	localparam word_t K_WEYL     = 64'h9e3779b97f4a7c15;
	localparam logic [5:0] PCG_SHIFT_BIAS = 6'd5;

	// alphabet
	localparam logic [13:0] ALPHABET_SCALE = 14'd52;
	localparam logic [5:0]  ALPHABET_SIZE  = 6'd52;
	localparam logic [5:0]  ALPHABET_HALF  = 6'd26;
	localparam logic [5:0]  ALPHABET_TOP   = 6'd51;
	localparam logic [7:0]  LETTER_UPPER_A = 8'h41;
	localparam logic [7:0]  LETTER_LOWER_A = 8'h61;

	// shared multiplier request and response
	typedef struct packed {
		logic  start;
		word_t a;
		word_t b;
	} mul_req_t;

	typedef struct packed {
		logic  done;
		word_t product;
	} mul_rsp_t;

	// word draw request and response
	typedef struct packed {
		logic       start;
		logic [2:0] gen_sel;
		word_t      state;
	} draw_req_t;

	typedef struct packed {
		logic  done;
		word_t word;
		word_t state;
	} draw_rsp_t;

	// map one byte to a letter A-Z or a-z
	function automatic logic [7:0] letter_of(input logic [7:0] b, input logic map_sel);
		logic [13:0] scaled;
		logic [5:0]  idx;
		scaled = {6'd0, b} * ALPHABET_SCALE;
		if (map_sel == MAP_MASK) begin
			idx = b[5:0];
			if (idx > ALPHABET_TOP) begin
				idx = idx - ALPHABET_SIZE;
			end
		end else begin
			idx = scaled[13:8];
		end
		if (idx < ALPHABET_HALF) begin
			return LETTER_UPPER_A + {2'd0, idx};
		end
		return LETTER_LOWER_A + {2'd0, idx - ALPHABET_HALF};
	endfunction

endpackage

// ===== rtl/core/random_letter_line_generator.sv =====
// top level: command handshake, line control, configuration and letter output
//
// Usage: configure through cfg_write/cfg_index/cfg_data while idle (generator,
// letter map, line length, line count, zero-seed substitute). Send a start
// command with a seed, then one next command per character. Each input
// transfer yields exactly one output transfer: a start reply, a letter,
// a newline closing a line (last set on the final newline), or an error.
// out_valid rises in the cycle after an input transfer that needs no fresh
// word. A letter that needs a fresh 64-bit word first runs the draw unit: no
// multiply for xorshift, weyl and weyl-xor, one for xorshift64* and two for
// wyrand and pcg, on the shared 32x32 multiplier. A fresh word serves up to
// eight letters; a start, or a new line at line length 20, drops the rest.
// One item is in flight at a time; in_ready is low while a word is drawn.
// The next item is taken in the cycle the pending result is transferred.
// Receiver stall: the result holds in the output register and in_ready stays
// low until out_ready takes it. Reset: configuration returns to its defaults,
// no job is active and both channels are empty.
module random_letter_line_generator (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        command,
	input  logic [63:0] seed,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  character,
	output logic        end_of_line,
	output logic        last,
	output logic [1:0]  status,
	input  logic        cfg_write,
	input  logic [2:0]  cfg_index,
	input  logic [63:0] cfg_data
);
	import rlg_pkg::*;

	`include "random_letter_line_generator_assert.svh"

	// configuration registers
	logic [2:0]  gen_sel_q;
	logic        map_sel_q;
	logic [12:0] line_length_q;
	logic [31:0] line_count_q;
	word_t       substitute_q;

	// job state
	word_t       gen_state_q;
	word_t       buf_q;
	logic [2:0]  bytes_q;
	logic [12:0] letters_left_q;
	logic [31:0] lines_left_q;
	logic        job_active_q;
	logic        busy_q;

	// output register
	logic        out_valid_q;
	logic [7:0]  char_q;
	logic        eol_q;
	logic        last_q;
	logic [1:0]  status_q;

	logic        in_accept;
	logic        start_bad;
	logic [12:0] reload_len;
	logic        need_word;
	logic [7:0]  buf_letter;
	logic [7:0]  fresh_letter;
	draw_req_t   draw_req;
	draw_rsp_t   draw_rsp;

	// handshake and decode
	assign in_ready   = !busy_q && (!out_valid_q || out_ready);
	assign in_accept  = in_valid && in_ready;
	assign start_bad  = (line_count_q == 32'd0) || (line_length_q == 13'd0)
		|| (line_length_q > MAX_LINE_LENGTH);
	assign reload_len = (line_length_q > MAX_LINE_LENGTH) ? MAX_LINE_LENGTH : line_length_q;
	assign need_word  = (command == CMD_NEXT) && job_active_q && (letters_left_q != 13'd0)
		&& (bytes_q == 3'd0);

	// letter mapping
	assign buf_letter   = letter_of(buf_q[7:0], map_sel_q);
	assign fresh_letter = letter_of(draw_rsp.word[7:0], map_sel_q);

	// word draw unit
	assign draw_req.start   = in_accept && need_word;
	assign draw_req.gen_sel = gen_sel_q;
	assign draw_req.state   = gen_state_q;

	rlg_draw u_draw (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (draw_req),
		.rsp    (draw_rsp)
	);

	// configuration, job control and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gen_sel_q      <= GEN_XORSHIFT_STAR;
			map_sel_q      <= MAP_SCALED;
			line_length_q  <= RESET_LINE_LEN;
			line_count_q   <= RESET_LINE_COUNT;
			substitute_q   <= RESET_SUBSTITUTE;
			gen_state_q    <= '0;
			buf_q          <= '0;
			bytes_q        <= '0;
			letters_left_q <= '0;
			lines_left_q   <= '0;
			job_active_q   <= 1'b0;
			busy_q         <= 1'b0;
			out_valid_q    <= 1'b0;
			char_q         <= '0;
			eol_q          <= 1'b0;
			last_q         <= 1'b0;
			status_q       <= STATUS_OK;
		end else begin
			// register writes
			if (cfg_write) begin
				unique case (cfg_index)
					REG_GENERATOR_SELECT:     gen_sel_q     <= cfg_data[2:0];
					REG_LETTER_MAP_SELECT:    map_sel_q     <= cfg_data[0];
					REG_LINE_LENGTH:          line_length_q <= cfg_data[12:0];
					REG_LINE_COUNT:           line_count_q  <= cfg_data[31:0];
					REG_ZERO_SEED_SUBSTITUTE: substitute_q  <= cfg_data;
					default: ;
				endcase
			end

			// output transfer frees the register
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end

			// input transfer
			if (in_accept) begin
				char_q   <= '0;
				eol_q    <= 1'b0;
				last_q   <= 1'b0;
				status_q <= STATUS_OK;
				if (command == CMD_START) begin
					out_valid_q <= 1'b1;
					if (start_bad) begin
						job_active_q <= 1'b0;
						status_q     <= STATUS_INVALID;
					end else begin
						gen_state_q    <= (seed == 64'd0) ? substitute_q : seed;
						buf_q          <= '0;
						bytes_q        <= '0;
						letters_left_q <= line_length_q;
						lines_left_q   <= line_count_q;
						job_active_q   <= 1'b1;
					end
				end else if (!job_active_q) begin
					out_valid_q <= 1'b1;
					status_q    <= STATUS_NO_JOB;
				end else if (letters_left_q != 13'd0) begin
					if (bytes_q == 3'd0) begin
						busy_q <= 1'b1;
					end else begin
						out_valid_q    <= 1'b1;
						char_q         <= buf_letter;
						buf_q          <= buf_q >> 8;
						bytes_q        <= bytes_q - 3'd1;
						letters_left_q <= letters_left_q - 13'd1;
					end
				end else begin
					// newline closes the line
					out_valid_q  <= 1'b1;
					char_q       <= NEWLINE;
					eol_q        <= 1'b1;
					lines_left_q <= lines_left_q - 32'd1;
					if (lines_left_q == 32'd1) begin
						last_q       <= 1'b1;
						job_active_q <= 1'b0;
					end else begin
						letters_left_q <= reload_len;
						if (line_length_q == LENGTH_RESEED) begin
							bytes_q <= '0;
							buf_q   <= '0;
						end
					end
				end
			end

			// fresh word arrives
			if (busy_q && draw_rsp.done) begin
				busy_q         <= 1'b0;
				gen_state_q    <= draw_rsp.state;
				buf_q          <= draw_rsp.word >> 8;
				bytes_q        <= BYTES_AFTER_DRAW;
				letters_left_q <= letters_left_q - 13'd1;
				out_valid_q    <= 1'b1;
				char_q         <= fresh_letter;
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign character   = char_q;
	assign end_of_line = eol_q;
	assign last        = last_q;
	assign status      = status_q;

	// checks
	`RLG_ASSERT_IMPL(a_draw_done_busy, draw_rsp.done, busy_q)
	`RLG_ASSERT_IMPL(a_draw_out_empty, busy_q && draw_rsp.done, !out_valid_q)
	`RLG_ASSERT_IMPL(a_eol_newline, out_valid_q && eol_q, char_q == NEWLINE && status_q == STATUS_OK)
	`RLG_ASSERT_IMPL(a_last_ends_job, out_valid_q && last_q, eol_q && !job_active_q)

endmodule

// ===== rtl/core/rlg_mul.sv =====
// shared 64 by 64 low-half multiplier built from one 32 by 32 unit
module rlg_mul (
	input  logic              clk,
	input  logic              arst_n,
	input  rlg_pkg::mul_req_t req,
	output rlg_pkg::mul_rsp_t rsp
);
	import rlg_pkg::*;

	localparam logic [1:0] STEP_LL = 2'd0;
	localparam logic [1:0] STEP_LH = 2'd1;
	localparam logic [1:0] STEP_HL = 2'd2;

	logic        busy_q;
	logic        done_q;
	logic [1:0]  step_q;
	word_t       a_q;
	word_t       b_q;
	word_t       acc_q;
	logic [31:0] op_a;
	logic [31:0] op_b;
	logic [63:0] prod;

	// partial product operand select
	always_comb begin
		case (step_q)
			STEP_LH: begin
				op_a = a_q[31:0];
				op_b = b_q[63:32];
			end
			STEP_HL: begin
				op_a = a_q[63:32];
				op_b = b_q[31:0];
			end
			default: begin
				op_a = a_q[31:0];
				op_b = b_q[31:0];
			end
		endcase
	end

	assign prod = 64'(op_a) * 64'(op_b);

	// step sequencing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= STEP_LL;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				step_q <= STEP_LL;
			end else if (busy_q) begin
				if (step_q == STEP_HL) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					step_q <= step_q + 2'd1;
				end
			end
		end
	end

	// operands and accumulator
	always_ff @(posedge clk) begin
		if (req.start) begin
			a_q <= req.a;
			b_q <= req.b;
		end
		if (busy_q) begin
			case (step_q) inside
				STEP_LH, STEP_HL: acc_q <= acc_q + {prod[31:0], 32'd0};
				default:          acc_q <= prod;
			endcase
		end
	end

	assign rsp.done    = done_q;
	assign rsp.product = acc_q;

endmodule

// ===== rtl/core/rlg_draw.sv =====
// word draw sequencer: runs one generator step, using the shared multiplier for xorshift64*, wyrand and pcg
module rlg_draw (
	input  logic               clk,
	input  logic               arst_n,
	input  rlg_pkg::draw_req_t req,
	output rlg_pkg::draw_rsp_t rsp
);
	import rlg_pkg::*;

	localparam logic [1:0] D_IDLE = 2'd0;
	localparam logic [1:0] D_MUL1 = 2'd1;
	localparam logic [1:0] D_MUL2 = 2'd2;

	logic [1:0] fsm_q;
	logic       done_q;
	logic [2:0] sel_q;
	word_t      x_q;
	word_t      state_q;
	word_t      word_q;

	mul_req_t   mul_req;
	mul_rsp_t   mul_rsp;

	word_t      xs1, xs2, xs_star;
	word_t      xr1, xr2, xs_raw;
	word_t      weyl;
	word_t      wy_x;
	word_t      p;
	word_t      wy_mid;
	logic [5:0] pcg_shift;
	word_t      pcg_mix;

	// combinational generator pieces
	always_comb begin
		xs1       = req.state ^ (req.state >> 12);
		xs2       = xs1 ^ (xs1 << 25);
		xs_star   = xs2 ^ (xs2 >> 27);
		xr1       = req.state ^ (req.state << 13);
		xr2       = xr1 ^ (xr1 >> 7);
		xs_raw    = xr2 ^ (xr2 << 17);
		weyl      = req.state + K_WEYL;
		wy_x      = req.state + K_WY_ADD;
		p         = mul_rsp.product;
		wy_mid    = p ^ (p >> 32);
		pcg_shift = {1'b0, x_q[63:59]} + PCG_SHIFT_BIAS;
		pcg_mix   = (x_q >> pcg_shift) ^ x_q;
	end

	// multiplier requests
	always_comb begin
		mul_req.start = 1'b0;
		mul_req.a     = xs_star;
		mul_req.b     = K_STAR;
		if (req.start) begin
			case (req.gen_sel) inside
				GEN_WYRAND: begin
					mul_req.start = 1'b1;
					mul_req.a     = wy_x ^ (wy_x >> 32);
					mul_req.b     = K_WY_MUL1;
				end
				GEN_PCG: begin
					mul_req.start = 1'b1;
					mul_req.a     = req.state;
					mul_req.b     = K_PCG_MUL;
				end
				GEN_XORSHIFT, GEN_WEYL, GEN_WEYL_XOR: mul_req.start = 1'b0;
				default: mul_req.start = 1'b1;
			endcase
		end else if (fsm_q == D_MUL1 && mul_rsp.done) begin
			case (sel_q)
				GEN_WYRAND: begin
					mul_req.start = 1'b1;
					mul_req.a     = wy_mid;
					mul_req.b     = K_WY_MUL2;
				end
				GEN_PCG: begin
					mul_req.start = 1'b1;
					mul_req.a     = pcg_mix;
					mul_req.b     = K_PCG_OUT;
				end
				default: mul_req.start = 1'b0;
			endcase
		end
	end

	rlg_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mul_req),
		.rsp    (mul_rsp)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fsm_q  <= D_IDLE;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (fsm_q)
				D_IDLE: begin
					if (req.start) begin
						case (req.gen_sel) inside
							GEN_XORSHIFT, GEN_WEYL, GEN_WEYL_XOR: done_q <= 1'b1;
							default: fsm_q <= D_MUL1;
						endcase
					end
				end
				D_MUL1: begin
					if (mul_rsp.done) begin
						case (sel_q) inside
							GEN_WYRAND, GEN_PCG: fsm_q <= D_MUL2;
							default: begin
								fsm_q  <= D_IDLE;
								done_q <= 1'b1;
							end
						endcase
					end
				end
				D_MUL2: begin
					if (mul_rsp.done) begin
						fsm_q  <= D_IDLE;
						done_q <= 1'b1;
					end
				end
				default: fsm_q <= D_IDLE;
			endcase
		end
	end

	// next state and word
	always_ff @(posedge clk) begin
		if (req.start) begin
			sel_q <= req.gen_sel;
			x_q   <= req.state;
			case (req.gen_sel)
				GEN_WYRAND: state_q <= wy_x;
				GEN_PCG:    state_q <= state_q;
				GEN_XORSHIFT: begin
					state_q <= xs_raw;
					word_q  <= xs_raw;
				end
				GEN_WEYL: begin
					state_q <= weyl;
					word_q  <= weyl;
				end
				GEN_WEYL_XOR: begin
					state_q <= weyl;
					word_q  <= weyl ^ (weyl >> 31) ^ (weyl << 11);
				end
				default: state_q <= xs_star;
			endcase
		end else if (mul_rsp.done) begin
			if (fsm_q == D_MUL1) begin
				case (sel_q)
					GEN_WYRAND: word_q  <= word_q;
					GEN_PCG:    state_q <= p + K_PCG_ADD;
					default:    word_q  <= p;
				endcase
			end else if (fsm_q == D_MUL2) begin
				case (sel_q)
					GEN_WYRAND: word_q <= wy_mid;
					default:    word_q <= (p >> 43) ^ p;
				endcase
			end
		end
	end

	assign rsp.done  = done_q;
	assign rsp.word  = word_q;
	assign rsp.state = state_q;

endmodule

// ===== test/tb_random_letter_line_generator.sv =====
// self-checking testbench for the random letter line generator with a predicting scoreboard
module tb_random_letter_line_generator;
	import rlg_pkg::*;

	localparam int unsigned RANDOM_ITEMS = 700;
	localparam int unsigned REPORT_LINES = 40;

	// one result transfer as seen on the output channel
	typedef struct packed {
		logic [7:0] character;
		logic       eol;
		logic       last;
		logic [1:0] status;
	} line_char_t;

	// predicts the character stream and checks it against the output
	class char_scoreboard;
		logic [2:0]  gen_sel;
		logic        map_sel;
		logic [12:0] line_len;
		logic [31:0] line_cnt;
		word_t       zero_sub;

		word_t       gen_state;
		word_t       word_buf;
		logic [3:0]  bytes_left;
		logic [12:0] letters_left;
		logic [31:0] lines_left;
		bit          job_running;

		line_char_t  expected_chars[$];
		int unsigned errors;

		function new();
			gen_sel      = GEN_XORSHIFT_STAR;
			map_sel      = MAP_SCALED;
			line_len     = RESET_LINE_LEN;
			line_cnt     = RESET_LINE_COUNT;
			zero_sub     = RESET_SUBSTITUTE;
			gen_state    = '0;
			word_buf     = '0;
			bytes_left   = '0;
			letters_left = '0;
			lines_left   = '0;
			job_running  = 0;
			errors       = 0;
		endfunction

		function void apply_register(logic [2:0] idx, word_t data);
			case (idx)
				REG_GENERATOR_SELECT:     gen_sel  = data[2:0];
				REG_LETTER_MAP_SELECT:    map_sel  = data[0];
				REG_LINE_LENGTH:          line_len = data[12:0];
				REG_LINE_COUNT:           line_cnt = data[31:0];
				REG_ZERO_SEED_SUBSTITUTE: zero_sub = data;
				default: ;
			endcase
		endfunction

		// advance the selected generator and return its next 64-bit word
		function word_t roll_word();
			word_t x;
			word_t w;
			x = gen_state;
			case (gen_sel)
				GEN_WYRAND: begin
					x = x + K_WY_ADD;
					gen_state = x;
					x = x ^ (x >> 32);
					x = x * K_WY_MUL1;
					x = x ^ (x >> 32);
					x = x * K_WY_MUL2;
					return x ^ (x >> 32);
				end
				GEN_PCG: begin
					gen_state = x * K_PCG_MUL + K_PCG_ADD;
					w = ((x >> ((x >> 59) + PCG_SHIFT_BIAS)) ^ x) * K_PCG_OUT;
					return (w >> 43) ^ w;
				end
				GEN_XORSHIFT: begin
					x = x ^ (x << 13);
					x = x ^ (x >> 7);
					x = x ^ (x << 17);
					gen_state = x;
					return x;
				end
				GEN_WEYL: begin
					gen_state = x + K_WEYL;
					return gen_state;
				end
				GEN_WEYL_XOR: begin
					x = x + K_WEYL;
					gen_state = x;
					return x ^ (x >> 31) ^ (x << 11);
				end
				default: begin
					// xorshift64*, also taken by the unused selects
					x = x ^ (x >> 12);
					x = x ^ (x << 25);
					x = x ^ (x >> 27);
					gen_state = x;
					return x * K_STAR;
				end
			endcase
		endfunction

		// byte to letter index 0..51, then into the two letter ranges
		function logic [7:0] map_byte(logic [7:0] b);
			logic [13:0] prod;
			logic [5:0]  idx;
			prod = {6'd0, b} * 14'd52;
			if (map_sel == MAP_MASK) begin
				idx = (b[5:0] >= 6'd52) ? b[5:0] - 6'd52 : b[5:0];
			end else begin
				idx = prod[13:8];
			end
			if (idx >= 6'd26) begin
				return LETTER_LOWER_A + {2'd0, idx} - 8'd26;
			end
			return LETTER_UPPER_A + {2'd0, idx};
		endfunction

		// predict the result of one accepted input transfer
		function void note_command(logic cmd, word_t seed_val);
			line_char_t r;
			r = '0;
			r.status = STATUS_OK;
			if (cmd == CMD_START) begin
				if (line_cnt == 0 || line_len == 0 || line_len > MAX_LINE_LENGTH) begin
					job_running = 0;
					r.status = STATUS_INVALID;
				end else begin
					gen_state    = (seed_val == 0) ? zero_sub : seed_val;
					word_buf     = '0;
					bytes_left   = '0;
					letters_left = line_len;
					lines_left   = line_cnt;
					job_running  = 1;
				end
			end else if (!job_running) begin
				r.status = STATUS_NO_JOB;
			end else if (letters_left != 0) begin
				if (bytes_left == 0) begin
					word_buf   = roll_word();
					bytes_left = 4'd8;
				end
				r.character  = map_byte(word_buf[7:0]);
				word_buf     = word_buf >> 8;
				bytes_left   = bytes_left - 4'd1;
				letters_left = letters_left - 13'd1;
			end else begin
				// newline closes the line; next line length is read again here
				r.character = NEWLINE;
				r.eol       = 1'b1;
				lines_left  = lines_left - 32'd1;
				if (lines_left == 0) begin
					r.last      = 1'b1;
					job_running = 0;
				end else begin
					letters_left = (line_len > MAX_LINE_LENGTH) ? MAX_LINE_LENGTH : line_len;
					if (line_len == LENGTH_RESEED) begin
						bytes_left = '0;
						word_buf   = '0;
					end
				end
			end
			expected_chars.push_back(r);
		endfunction

		task report(string msg);
			if (errors < REPORT_LINES) begin
				$display("mismatch at %0t: %s", $realtime, msg);
			end
			errors++;
		endtask

		// compare one output transfer with the oldest prediction
		task check_char(logic [7:0] c, logic e, logic l, logic [1:0] s);
			line_char_t got;
			line_char_t want;
			got = {c, e, l, s};
			if (expected_chars.size() == 0) begin
				report($sformatf("unexpected result char=%h eol=%b last=%b status=%0d",
					c, e, l, s));
				return;
			end
			want = expected_chars.pop_front();
			if (got.character !== want.character || got.eol !== want.eol ||
				got.last !== want.last || got.status !== want.status) begin
				report($sformatf("got char=%h eol=%b last=%b status=%0d, want %h %b %b %0d",
					got.character, got.eol, got.last, got.status,
					want.character, want.eol, want.last, want.status));
			end
		endtask
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic        command = CMD_NEXT;
	logic [63:0] seed = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [7:0]  character;
	logic        end_of_line;
	logic        last;
	logic [1:0]  status;
	logic        cfg_write = 1'b0;
	logic [2:0]  cfg_index = '0;
	logic [63:0] cfg_data = '0;

	char_scoreboard sb = new();
	bit             steady = 0;
	int unsigned    items_sent = 0;

	random_letter_line_generator DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.command    (command),
		.seed       (seed),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.character  (character),
		.end_of_line(end_of_line),
		.last       (last),
		.status     (status),
		.cfg_write  (cfg_write),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	always #1 clk = ~clk;

	// mostly short gaps, a few long ones, none in steady stretches
	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (steady || r < 50) begin
			return 0;
		end else if (r < 85) begin
			return $urandom_range(1, 3);
		end else if (r < 97) begin
			return $urandom_range(4, 10);
		end
		return $urandom_range(20, 60);
	endfunction

	function automatic word_t pick_seed();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 10) begin
			return '0;
		end else if (r < 15) begin
			return '1;
		end
		return {$urandom, $urandom};
	endfunction

	function automatic logic [2:0] pick_index();
		logic [2:0] idx;
		if ($urandom_range(0, 99) < 90) begin
			idx = 3'($urandom_range(0, 4));
		end else begin
			idx = 3'($urandom_range(5, 7));
		end
		return idx;
	endfunction

	// register value with occasional junk above the register width
	function automatic word_t pick_reg_value(logic [2:0] idx);
		word_t       v;
		logic [12:0] len;
		logic [31:0] cnt;
		int unsigned r;
		v = {$urandom, $urandom};
		if ($urandom_range(0, 2) != 0) begin
			v = '0;
		end
		r = $urandom_range(0, 99);
		case (idx)
			REG_GENERATOR_SELECT:  v[2:0] = 3'($urandom_range(0, 7));
			REG_LETTER_MAP_SELECT: v[0] = 1'($urandom_range(0, 1));
			REG_LINE_LENGTH: begin
				if (r < 65)      len = 13'($urandom_range(1, 8));
				else if (r < 75) len = LENGTH_RESEED;
				else if (r < 80) len = '0;
				else if (r < 85) len = MAX_LINE_LENGTH;
				else if (r < 92) len = 13'($urandom_range(4097, 8191));
				else             len = 13'($urandom_range(9, 40));
				v[12:0] = len;
			end
			REG_LINE_COUNT: begin
				if (r < 70)      cnt = $urandom_range(1, 3);
				else if (r < 78) cnt = '0;
				else if (r < 90) cnt = $urandom_range(4, 8);
				else if (r < 95) cnt = '1;
				else             cnt = $urandom;
				v[31:0] = cnt;
			end
			REG_ZERO_SEED_SUBSTITUTE: begin
				if (r < 15)      v = '0;
				else if (r < 25) v = '1;
				else             v = {$urandom, $urandom};
			end
			default: v = {$urandom, $urandom};
		endcase
		return v;
	endfunction

	// one input transfer, after a random gap
	task automatic send_cmd(logic cmd, word_t seed_val);
		int unsigned gap;
		gap = pick_gap();
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		command  <= cmd;
		seed     <= seed_val;
		do @(posedge clk); while (!in_ready);
		sb.note_command(cmd, seed_val);
		items_sent++;
	endtask

	// register write, lands at the next edge; caller lowers cfg_write
	task automatic write_reg(logic [2:0] idx, word_t data);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		sb.apply_register(idx, data);
	endtask

	// drop valid and wait until every predicted result has come out
	task automatic settle();
		in_valid <= 1'b0;
		do @(posedge clk); while (sb.expected_chars.size() != 0);
	endtask

	task automatic send_nexts(int unsigned n);
		repeat (n) send_cmd(CMD_NEXT, pick_seed());
	endtask

	// output side: ready stretches broken by random stalls
	initial begin
		int unsigned stall;
		@(posedge arst_n);
		forever begin
			out_ready <= 1'b1;
			repeat ($urandom_range(1, 20)) @(posedge clk);
			stall = pick_gap();
			if (stall != 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
		end
	end

	// check every output transfer
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			sb.check_char(character, end_of_line, last, status);
		end
	end

	initial begin
		int unsigned n;
		int unsigned nw;
		logic [2:0]  idx;
		bit          started;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// next with no job, then a start rejected for zero length
		send_cmd(CMD_NEXT, '1);
		settle();
		write_reg(REG_LINE_LENGTH, 64'd0);
		cfg_write <= 1'b0;
		send_cmd(CMD_START, pick_seed());
		settle();

		// zero seed with zero substitute: generator runs from zero; two full lines
		write_reg(REG_LINE_LENGTH, 64'd3);
		write_reg(REG_LINE_COUNT, 64'd2);
		write_reg(REG_ZERO_SEED_SUBSTITUTE, 64'd0);
		cfg_write <= 1'b0;
		send_cmd(CMD_START, '0);
		send_nexts(9);
		settle();

		// length just past the maximum, then maximum length with zero count
		write_reg(REG_LINE_LENGTH, 64'd4097);
		cfg_write <= 1'b0;
		send_cmd(CMD_START, pick_seed());
		settle();
		write_reg(REG_LINE_LENGTH, {51'd0, MAX_LINE_LENGTH});
		write_reg(REG_LINE_COUNT, 64'd0);
		cfg_write <= 1'b0;
		send_cmd(CMD_START, pick_seed());
		settle();

		// endless job, restarted while active
		write_reg(REG_LINE_COUNT, 64'hffff_ffff);
		write_reg(REG_LINE_LENGTH, 64'd2);
		write_reg(REG_GENERATOR_SELECT, {61'd0, GEN_WEYL_XOR});
		write_reg(REG_LETTER_MAP_SELECT, {63'd0, MAP_MASK});
		write_reg(REG_ZERO_SEED_SUBSTITUTE, '1);
		cfg_write <= 1'b0;
		send_cmd(CMD_START, '0);
		send_cmd(CMD_NEXT, '0);
		send_cmd(CMD_START, '1);
		send_nexts(2);
		settle();

		// length changed mid-job: empty lines, then a saturated length
		write_reg(REG_LINE_LENGTH, 64'd0);
		cfg_write <= 1'b0;
		send_nexts(2);
		settle();
		write_reg(REG_LINE_LENGTH, 64'd5000);
		cfg_write <= 1'b0;
		send_nexts(2);
		settle();

		// start rejected while a job runs drops the job
		send_cmd(CMD_START, pick_seed());
		send_cmd(CMD_NEXT, '0);
		settle();

		// random phases: config between phases, mostly whole jobs
		items_sent = 0;
		while (items_sent < RANDOM_ITEMS) begin
			steady = ($urandom_range(0, 4) == 0);
			if ($urandom_range(0, 9) < 6) begin
				nw = $urandom_range(1, 3);
				repeat (nw) begin
					idx = pick_index();
					write_reg(idx, pick_reg_value(idx));
				end
				cfg_write <= 1'b0;
			end
			if ($urandom_range(0, 4) == 0) begin
				// noise: random commands in any order
				repeat ($urandom_range(1, 8)) begin
					send_cmd(($urandom_range(0, 3) == 0) ? CMD_START : CMD_NEXT, pick_seed());
				end
			end else begin
				started = 0;
				if (!sb.job_running || $urandom_range(0, 9) != 0) begin
					send_cmd(CMD_START, pick_seed());
					started = 1;
				end
				if (!sb.job_running) begin
					n = $urandom_range(1, 3);
				end else if (!started || sb.line_cnt > 8 || sb.line_len > 40) begin
					n = $urandom_range(1, 30);
				end else begin
					n = sb.line_cnt * (sb.line_len + 13'd1) + $urandom_range(0, 2);
				end
				send_nexts(n);
			end
			settle();
		end

		steady = 0;
		repeat (20) @(posedge clk);
		if (sb.expected_chars.size() != 0) begin
			sb.report("expected results left over");
		end
		if (sb.errors == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

	// watchdog
	initial begin
		#3000000;
		$display("== FAIL ==");
		$finish;
	end

endmodule
